[rtl/video_flash_frame_detector_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the flash frame detector checker
// ----------------------------------------------------------------------------
`ifndef VIDEO_FLASH_FRAME_DETECTOR_ASSERT_SVH
`define VIDEO_FLASH_FRAME_DETECTOR_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted
`define VFFD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define VFFD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/vffd_pkg.sv]
// ----------------------------------------------------------------------------
// vffd_pkg
// Shared widths, codes, types and the channel difference function of the
// flash frame detector.
// ----------------------------------------------------------------------------
package vffd_pkg;

    localparam int unsigned WINDOW_FRAMES_DEF = 8;

    localparam int unsigned MEAN_W     = 16;
    localparam int unsigned N_CHAN     = 3;
    localparam int unsigned SAMPLE_W   = N_CHAN * MEAN_W;
    localparam int unsigned THRESH_W   = 18;
    localparam int unsigned MIDDLE_W   = 6;
    localparam int unsigned FRAME_W    = 20;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 18;

    localparam logic [THRESH_W-1:0] RISE_RESET   = 18'd15360;
    localparam logic [THRESH_W-1:0] RETURN_RESET = 18'd3840;
    localparam logic [MIDDLE_W-1:0] MIDDLE_RESET = 6'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RISE   = 2'd0,
        CFG_RETURN = 2'd1,
        CFG_MIDDLE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [THRESH_W-1:0] rise;
        logic [THRESH_W-1:0] ret;
        logic [MIDDLE_W-1:0] max_middle;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BASE = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    // Sum of absolute per-channel differences of two packed means
    function automatic logic [THRESH_W-1:0] mean_diff(input logic [SAMPLE_W-1:0] a,
                                                      input logic [SAMPLE_W-1:0] b);
        logic [MEAN_W-1:0]   x;
        logic [MEAN_W-1:0]   y;
        logic [MEAN_W-1:0]   d;
        logic [THRESH_W-1:0] acc;
        acc = '0;
        for (int c = 0; c < N_CHAN; c++) begin
            x   = a[c*MEAN_W +: MEAN_W];
            y   = b[c*MEAN_W +: MEAN_W];
            d   = (x > y) ? (x - y) : (y - x);
            acc = acc + {{(THRESH_W-MEAN_W){1'b0}}, d};
        end
        return acc;
    endfunction

endpackage

[rtl/vffd_ring_mem.sv]
// ----------------------------------------------------------------------------
// vffd_ring_mem
// Single-port-write, single-port-read synchronous memory holding the ring of
// frame means; read data is registered.
// ----------------------------------------------------------------------------
module vffd_ring_mem #(
    parameter int unsigned DEPTH  = vffd_pkg::WINDOW_FRAMES_DEF + 1,
    parameter int unsigned DATA_W = vffd_pkg::SAMPLE_W
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/vffd_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// vffd_scan_ctrl
// Ring bookkeeping, window scan sequencer, flash marks and result register.
// Reads one stored mean per cycle from the ring memory and decides the
// oldest frame.
// ----------------------------------------------------------------------------
module vffd_scan_ctrl #(
    parameter int unsigned WINDOW_FRAMES = vffd_pkg::WINDOW_FRAMES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  vffd_pkg::cfg_t                       cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [vffd_pkg::SAMPLE_W-1:0]        s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [vffd_pkg::FRAME_W-1:0]         m_frame_number,
    output logic                                 m_is_flash,
    output logic                                 m_is_last,
    output logic                                 mem_wr_en,
    output logic [$clog2(WINDOW_FRAMES+1)-1:0]   mem_wr_addr,
    output logic [vffd_pkg::SAMPLE_W-1:0]        mem_wr_data,
    output logic [$clog2(WINDOW_FRAMES+1)-1:0]   mem_rd_addr,
    input  logic [vffd_pkg::SAMPLE_W-1:0]        mem_rd_data
);

    localparam int unsigned DEPTH    = WINDOW_FRAMES + 1;
    localparam int unsigned PTR_W    = $clog2(DEPTH);
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W    = CNT_W + 1;
    localparam int unsigned FRAME_W  = vffd_pkg::FRAME_W;
    localparam int unsigned SAMPLE_W = vffd_pkg::SAMPLE_W;
    localparam int unsigned THRESH_W = vffd_pkg::THRESH_W;
    localparam int unsigned MID_W    = vffd_pkg::MIDDLE_W + 1;

    // Physical slot of a logical offset from the oldest entry
    function automatic logic [PTR_W-1:0] ring_index(input logic [PTR_W-1:0] base,
                                                    input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Logical offset of a physical slot from the oldest entry
    function automatic logic [PTR_W-1:0] ring_offset(input logic [PTR_W-1:0] pos,
                                                     input logic [PTR_W-1:0] base);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + SUM_W'(DEPTH) - SUM_W'(base);
        if (pos >= base) begin
            sum = SUM_W'(pos) - SUM_W'(base);
        end
        return sum[PTR_W-1:0];
    endfunction

    vffd_pkg::state_t     state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [DEPTH-1:0]     marks_reg, marks_next;
    logic                 flush_reg, flush_next;
    logic                 out_valid_reg, out_valid_next;

    logic [SAMPLE_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [MID_W-1:0]     middle_reg, middle_next;
    logic                 look_high_reg, look_high_next;
    logic [FRAME_W-1:0]   out_frame_reg, out_frame_next;
    logic                 out_flash_reg, out_flash_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 out_free;
    logic [PTR_W-1:0]     wr_pos;
    logic [CNT_W-1:0]     idx_inc;
    logic [THRESH_W-1:0]  diff;
    logic [MID_W-1:0]     mid_n;
    logic                 scan_stop;

    assign s_ready  = (state_reg == vffd_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign wr_pos   = ring_index(head_reg, fill_reg);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign diff     = vffd_pkg::mean_diff(base_reg, mem_rd_data);

    assign mem_wr_addr = wr_pos;
    assign mem_wr_data = s_sample;

    // Pick the ring slot to read this cycle
    always_comb begin
        case (state_reg)
            vffd_pkg::ST_LOAD: mem_rd_addr = ring_index(head_reg, CNT_W'(1));
            vffd_pkg::ST_SCAN: mem_rd_addr = ring_index(head_reg, idx_inc);
            default:           mem_rd_addr = head_reg;
        endcase
    end

    // Sequencer: store, scan the window, emit the decision
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        frame_next     = frame_reg;
        marks_next     = marks_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        middle_next    = middle_reg;
        look_high_next = look_high_reg;
        out_frame_next = out_frame_reg;
        out_flash_next = out_flash_reg;
        out_last_next  = out_last_reg;
        mem_wr_en      = 1'b0;
        mid_n          = middle_reg;
        scan_stop      = 1'b0;

        // Drop the held result once taken
        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            vffd_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == vffd_pkg::OP_SAMPLE) begin
                        mem_wr_en          = 1'b1;
                        marks_next[wr_pos] = 1'b0;
                        fill_next          = fill_reg + CNT_W'(1);
                        frame_next         = frame_reg + FRAME_W'(1);
                        if (fill_reg == CNT_W'(DEPTH - 1)) begin
                            flush_next = 1'b0;
                            state_next = vffd_pkg::ST_LOAD;
                        end
                    end else if (fill_reg == '0) begin
                        head_next  = '0;
                        frame_next = '0;
                        marks_next = '0;
                    end else begin
                        flush_next = 1'b1;
                        state_next = vffd_pkg::ST_LOAD;
                    end
                end
            end
            vffd_pkg::ST_BASE: begin
                state_next = vffd_pkg::ST_LOAD;
            end
            vffd_pkg::ST_LOAD: begin
                base_next      = mem_rd_data;
                idx_next       = CNT_W'(1);
                middle_next    = '0;
                look_high_next = 1'b1;
                if (fill_reg > CNT_W'(1)) begin
                    state_next = vffd_pkg::ST_SCAN;
                end else begin
                    state_next = vffd_pkg::ST_EMIT;
                end
            end
            vffd_pkg::ST_SCAN: begin
                if (look_high_reg) begin
                    if (diff > cfg.rise) begin
                        look_high_next = 1'b0;
                    end else if (diff < cfg.ret) begin
                        scan_stop = 1'b1;
                    end else begin
                        mid_n = middle_reg + MID_W'(1);
                    end
                end else if (diff < cfg.ret) begin
                    // Mark every frame between the base and the return
                    scan_stop = 1'b1;
                    for (int p = 0; p < DEPTH; p++) begin
                        if ((ring_offset(PTR_W'(p), head_reg) != '0) &&
                            (CNT_W'(ring_offset(PTR_W'(p), head_reg)) < idx_reg)) begin
                            marks_next[p] = 1'b1;
                        end
                    end
                end
                middle_next = mid_n;
                idx_next    = idx_inc;
                if (scan_stop || (mid_n > MID_W'(cfg.max_middle)) ||
                    (idx_inc > CNT_W'(WINDOW_FRAMES)) || (idx_inc >= fill_reg)) begin
                    state_next = vffd_pkg::ST_EMIT;
                end
            end
            vffd_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_frame_next = frame_reg - FRAME_W'(fill_reg);
                    out_flash_next = marks_reg[head_reg];
                    out_last_next  = flush_reg && (fill_reg == CNT_W'(1));
                    head_next      = ring_index(head_reg, CNT_W'(1));
                    fill_next      = fill_reg - CNT_W'(1);
                    if (flush_reg && (fill_reg != CNT_W'(1))) begin
                        state_next = vffd_pkg::ST_BASE;
                    end else if (flush_reg) begin
                        // End of flush: clear the ring state
                        head_next  = '0;
                        frame_next = '0;
                        marks_next = '0;
                        flush_next = 1'b0;
                        state_next = vffd_pkg::ST_IDLE;
                    end else begin
                        state_next = vffd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = vffd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vffd_pkg::ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            frame_reg     <= '0;
            marks_reg     <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            frame_reg     <= frame_next;
            marks_reg     <= marks_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan and result payload
    always_ff @(posedge aclk) begin
        base_reg      <= base_next;
        idx_reg       <= idx_next;
        middle_reg    <= middle_next;
        look_high_reg <= look_high_next;
        out_frame_reg <= out_frame_next;
        out_flash_reg <= out_flash_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_number = out_frame_reg;
    assign m_is_flash     = out_flash_reg;
    assign m_is_last      = out_last_reg;

endmodule

[rtl/video_flash_frame_detector.sv]
// A sample that completes a window is stored, then goes through ST_LOAD,
//   ST_SCAN (1..WINDOW_FRAMES entries, one per cycle) and ST_EMIT, which
//   registers its result. A sample with no decision leaves s_ready high; a
//   deciding sample holds it low until ST_EMIT is done, a flush until its last
//   frame is done, each result stretched by any stall on m_ready while held.
// Reset: synchronous, active low; clears control and marks, presets thresholds.
// ----------------------------------------------------------------------------
// video_flash_frame_detector
// Per-frame flash detector over a ring of recent frame means, with a
// configuration write port for the thresholds.
// ----------------------------------------------------------------------------
module video_flash_frame_detector #(
    parameter int unsigned WINDOW_FRAMES = vffd_pkg::WINDOW_FRAMES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [vffd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vffd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [vffd_pkg::MEAN_W-1:0]        s_red_mean,
    input  logic [vffd_pkg::MEAN_W-1:0]        s_green_mean,
    input  logic [vffd_pkg::MEAN_W-1:0]        s_blue_mean,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [vffd_pkg::FRAME_W-1:0]       m_frame_number,
    output logic                               m_is_flash,
    output logic                               m_is_last
);

    localparam int unsigned DEPTH = WINDOW_FRAMES + 1;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    logic [vffd_pkg::THRESH_W-1:0] rise_reg, rise_next;
    logic [vffd_pkg::THRESH_W-1:0] ret_reg, ret_next;
    logic [vffd_pkg::MIDDLE_W-1:0] middle_reg, middle_next;
    vffd_pkg::cfg_t                cfg;

    logic                          mem_wr_en;
    logic [PTR_W-1:0]              mem_wr_addr;
    logic [vffd_pkg::SAMPLE_W-1:0] mem_wr_data;
    logic [PTR_W-1:0]              mem_rd_addr;
    logic [vffd_pkg::SAMPLE_W-1:0] mem_rd_data;
    logic [vffd_pkg::SAMPLE_W-1:0] s_sample;

    // Decode configuration writes
    always_comb begin
        rise_next   = rise_reg;
        ret_next    = ret_reg;
        middle_next = middle_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                vffd_pkg::CFG_RISE:   rise_next   = cfg_wdata[vffd_pkg::THRESH_W-1:0];
                vffd_pkg::CFG_RETURN: ret_next    = cfg_wdata[vffd_pkg::THRESH_W-1:0];
                vffd_pkg::CFG_MIDDLE: middle_next = cfg_wdata[vffd_pkg::MIDDLE_W-1:0];
                default: begin
                    rise_next = rise_reg;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg   <= vffd_pkg::RISE_RESET;
            ret_reg    <= vffd_pkg::RETURN_RESET;
            middle_reg <= vffd_pkg::MIDDLE_RESET;
        end else begin
            rise_reg   <= rise_next;
            ret_reg    <= ret_next;
            middle_reg <= middle_next;
        end
    end

    assign cfg.rise       = rise_reg;
    assign cfg.ret        = ret_reg;
    assign cfg.max_middle = middle_reg;

    // Pack red low, blue high
    assign s_sample = {s_blue_mean, s_green_mean, s_red_mean};

    vffd_ring_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (vffd_pkg::SAMPLE_W)
    ) u_ring_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    vffd_scan_ctrl #(
        .WINDOW_FRAMES (WINDOW_FRAMES)
    ) u_scan_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_number (m_frame_number),
        .m_is_flash     (m_is_flash),
        .m_is_last      (m_is_last),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

endmodule

[rtl/vffd_checker.sv]
// ----------------------------------------------------------------------------
// vffd_checker
// Port-level checks on the flash frame detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "video_flash_frame_detector_assert.svh"

module vffd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_wr_en,
    input logic [vffd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [vffd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_opcode,
    input logic [vffd_pkg::MEAN_W-1:0]     s_red_mean,
    input logic [vffd_pkg::MEAN_W-1:0]     s_green_mean,
    input logic [vffd_pkg::MEAN_W-1:0]     s_blue_mean,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [vffd_pkg::FRAME_W-1:0]    m_frame_number,
    input logic                            m_is_flash,
    input logic                            m_is_last
);

    // Reset empties the result register
    `VFFD_ASSERT_RST(a_reset_empties_out, !aresetn |=> !m_valid, "result valid after reset")

    // Hold a stalled result transaction
    `VFFD_ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_frame_number) && $stable(m_is_flash) && $stable(m_is_last), "stalled result changed")

    // Input side only goes busy after taking a transaction
    `VFFD_ASSERT_CLK(a_busy_after_accept, $fell(s_ready) |-> $past(s_valid && s_ready), "ready dropped without a transaction")

endmodule

bind video_flash_frame_detector vffd_checker u_vffd_checker (.*);
